[hdl/dtgd_pkg.sv]
// Double tap detector package: event kinds, register indexes, reset values
// and structs shared by the core and the top level, and the channel widths.
// No dependencies.
`default_nettype none

package dtgd_pkg;

  // Event kind codes
  typedef enum logic [1:0] {
    KIND_POS_X   = 2'd0,
    KIND_POS_Y   = 2'd1,
    KIND_CONTACT = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLE       = 2'd0,
    CFG_TAP_MAX_DUR  = 2'd1,
    CFG_TAP_MAX_MOVE = 2'd2,
    CFG_DBL_MAX_GAP  = 2'd3
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MOVE_W     = 17;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] TAP_MAX_DUR_RST  = 16'd250;
  localparam logic [CFG_DATA_W-1:0] TAP_MAX_MOVE_RST = 16'd40;
  localparam logic [CFG_DATA_W-1:0] DBL_MAX_GAP_RST  = 16'd400;

  // Contact value that means touch down
  localparam logic signed [POS_W-1:0] CONTACT_DOWN = 16'sd1;

  typedef struct packed {
    logic                  enable;
    logic [CFG_DATA_W-1:0] tap_dur_max;
    logic [CFG_DATA_W-1:0] tap_move_max;
    logic [CFG_DATA_W-1:0] dbl_gap_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [POS_W-1:0] value;
    logic [TIME_W-1:0]       time_ms;
  } item_t;

  typedef struct packed {
    logic wake;
    logic tap;
  } res_t;

endpackage

`default_nettype wire

[hdl/dtgd_if.sv]
// Valid/ready channel interfaces for touch events and gesture results.
// Depends on dtgd_pkg.
`default_nettype none

interface dtgd_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         kind;
  logic signed [dtgd_pkg::POS_W-1:0]  value;
  logic [dtgd_pkg::TIME_W-1:0]        time_ms;

  modport source (output valid, output kind, output value, output time_ms, input ready);
  modport sink   (input valid, input kind, input value, input time_ms, output ready);
endinterface

interface dtgd_out_if;
  logic valid;
  logic ready;
  logic wake;
  logic tap;

  modport source (output valid, output wake, output tap, input ready);
  modport sink   (input valid, input wake, input tap, output ready);
endinterface

`default_nettype wire

[hdl/double_tap_gesture_detector.sv]
// Double tap gesture detector top level: configuration registers, input
// register, result register and the tracking core.
// Depends on dtgd_pkg, dtgd_if.sv and dtgd_core.
//
//   channel   direction  handshake      payload
//   in_chan   sink       valid/ready    kind, value, time_ms
//   out_chan  source     valid/ready    wake, tap
//   cfg_*     write      cfg_we         cfg_index, cfg_wdata
//
// One request per cycle is sustained while out_chan.ready stays high; a
// result passes through the input register, then the result register,
// before it can be taken.
// The core updates its tracking state as a request moves into the result
// register, so each request sees the state left by the one before it.
// A stall on out_chan holds the result register; one more request waits in
// the input register before in_chan.ready drops.
// Synchronous active-low reset clears control state, loads register defaults.
`default_nettype none

module double_tap_gesture_detector (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dtgd_in_if.sink                              in_chan,
  dtgd_out_if.source                           out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [dtgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dtgd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  dtgd_pkg::cfg_t  cfg_r;
  dtgd_pkg::item_t in_item_r;
  dtgd_pkg::res_t  out_res_r, core_res;
  logic            in_valid_r, out_valid_r;
  logic            move, in_ready;

  // Move a request from the input register into the result register
  assign move     = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !in_valid_r || move;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.wake  = out_res_r.wake;
  assign out_chan.tap   = out_res_r.tap;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= 1'b0;
      cfg_r.tap_dur_max  <= dtgd_pkg::TAP_MAX_DUR_RST;
      cfg_r.tap_move_max <= dtgd_pkg::TAP_MAX_MOVE_RST;
      cfg_r.dbl_gap_max  <= dtgd_pkg::DBL_MAX_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtgd_pkg::CFG_ENABLE:       cfg_r.enable       <= cfg_wdata[0];
        dtgd_pkg::CFG_TAP_MAX_DUR:  cfg_r.tap_dur_max  <= cfg_wdata;
        dtgd_pkg::CFG_TAP_MAX_MOVE: cfg_r.tap_move_max <= cfg_wdata;
        dtgd_pkg::CFG_DBL_MAX_GAP:  cfg_r.dbl_gap_max  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: hold the request until it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      in_item_r.kind    <= in_chan.kind;
      in_item_r.value   <= in_chan.value;
      in_item_r.time_ms <= in_chan.time_ms;
    end
  end

  dtgd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (move),
    .item_i (in_item_r),
    .cfg_i  (cfg_r),
    .res_o  (core_res)
  );

  // Result register: load on move, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res_r <= core_res;
    end
  end

  a_wake_is_tap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_res_r.wake || out_res_r.tap))
    else $error("wake without tap");

  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !move |=> in_valid_r)
    else $error("pending request lost");

  a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("result register not loaded");

endmodule

`default_nettype wire

[hdl/dtgd_core.sv]
// Gesture tracking core: position, down point, peak movement and tap
// history registers, updated once per processed request.
// Depends on dtgd_pkg.
`default_nettype none

module dtgd_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_i,
  input  wire dtgd_pkg::item_t  item_i,
  input  wire dtgd_pkg::cfg_t   cfg_i,
  output dtgd_pkg::res_t        res_o
);

  logic signed [dtgd_pkg::POS_W-1:0]  cur_x_r, cur_x_nxt;
  logic signed [dtgd_pkg::POS_W-1:0]  cur_y_r, cur_y_nxt;
  logic signed [dtgd_pkg::POS_W-1:0]  down_x_r, down_x_nxt;
  logic signed [dtgd_pkg::POS_W-1:0]  down_y_r, down_y_nxt;
  logic [dtgd_pkg::MOVE_W-1:0]        peak_r, peak_nxt;
  logic                               touch_tracking_r, touch_tracking_nxt;
  logic [dtgd_pkg::TIME_W-1:0]        down_time_r, down_time_nxt;
  logic [dtgd_pkg::TIME_W-1:0]        last_tap_time_r, last_tap_time_nxt;
  logic                               last_tap_valid_r, last_tap_valid_nxt;

  logic signed [dtgd_pkg::MOVE_W-1:0] diff_x, diff_y;
  logic [dtgd_pkg::MOVE_W-1:0]        dist_x, dist_y, cheb;
  logic [dtgd_pkg::TIME_W-1:0]        dur, gap;
  logic                               dur_ok, move_ok, gap_ok, is_pos, is_x;

  // Chebyshev distance of the updated position from the down point
  always_comb begin
    is_x   = (item_i.kind == dtgd_pkg::KIND_POS_X);
    is_pos = is_x || (item_i.kind == dtgd_pkg::KIND_POS_Y);
    cur_x_nxt = (is_x) ? item_i.value : cur_x_r;
    cur_y_nxt = (item_i.kind == dtgd_pkg::KIND_POS_Y) ? item_i.value : cur_y_r;
    diff_x = {cur_x_nxt[dtgd_pkg::POS_W-1], cur_x_nxt}
           - {down_x_r[dtgd_pkg::POS_W-1], down_x_r};
    diff_y = {cur_y_nxt[dtgd_pkg::POS_W-1], cur_y_nxt}
           - {down_y_r[dtgd_pkg::POS_W-1], down_y_r};
    dist_x = diff_x[dtgd_pkg::MOVE_W-1] ? dtgd_pkg::MOVE_W'(-diff_x) : dtgd_pkg::MOVE_W'(diff_x);
    dist_y = diff_y[dtgd_pkg::MOVE_W-1] ? dtgd_pkg::MOVE_W'(-diff_y) : dtgd_pkg::MOVE_W'(diff_y);
    cheb   = (dist_x > dist_y) ? dist_x : dist_y;
  end

  // Tap qualification with wrapping time differences
  always_comb begin
    dur     = item_i.time_ms - down_time_r;
    gap     = item_i.time_ms - last_tap_time_r;
    dur_ok  = dur <= {{(dtgd_pkg::TIME_W-dtgd_pkg::CFG_DATA_W){1'b0}}, cfg_i.tap_dur_max};
    gap_ok  = gap <= {{(dtgd_pkg::TIME_W-dtgd_pkg::CFG_DATA_W){1'b0}}, cfg_i.dbl_gap_max};
    move_ok = peak_r <= {1'b0, cfg_i.tap_move_max};
  end

  // Next state and result for the current request
  always_comb begin
    down_x_nxt         = down_x_r;
    down_y_nxt         = down_y_r;
    peak_nxt           = peak_r;
    touch_tracking_nxt = touch_tracking_r;
    down_time_nxt      = down_time_r;
    last_tap_time_nxt  = last_tap_time_r;
    last_tap_valid_nxt = last_tap_valid_r;
    res_o              = '0;
    if (!cfg_i.enable) begin
      touch_tracking_nxt = 1'b0;
      last_tap_valid_nxt = 1'b0;
    end else if (is_pos) begin
      if (touch_tracking_r && (cheb > peak_r)) begin
        peak_nxt = cheb;
      end
    end else if (item_i.kind == dtgd_pkg::KIND_CONTACT) begin
      if (item_i.value == dtgd_pkg::CONTACT_DOWN) begin
        down_time_nxt      = item_i.time_ms;
        down_x_nxt         = cur_x_r;
        down_y_nxt         = cur_y_r;
        peak_nxt           = '0;
        touch_tracking_nxt = 1'b1;
      end else if (touch_tracking_r) begin
        touch_tracking_nxt = 1'b0;
        if (!(dur_ok && move_ok)) begin
          last_tap_valid_nxt = 1'b0;
        end else if (last_tap_valid_r && gap_ok) begin
          last_tap_valid_nxt = 1'b0;
          res_o.wake         = 1'b1;
          res_o.tap          = 1'b1;
        end else begin
          last_tap_time_nxt  = item_i.time_ms;
          last_tap_valid_nxt = 1'b1;
          res_o.tap          = 1'b1;
        end
      end
    end
  end

  // Advance state on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r          <= '0;
      cur_y_r          <= '0;
      down_x_r         <= '0;
      down_y_r         <= '0;
      peak_r           <= '0;
      touch_tracking_r <= 1'b0;
      down_time_r      <= '0;
      last_tap_time_r  <= '0;
      last_tap_valid_r <= 1'b0;
    end else if (step_i) begin
      if (cfg_i.enable) begin
        cur_x_r <= cur_x_nxt;
        cur_y_r <= cur_y_nxt;
      end
      down_x_r         <= down_x_nxt;
      down_y_r         <= down_y_nxt;
      peak_r           <= peak_nxt;
      touch_tracking_r <= touch_tracking_nxt;
      down_time_r      <= down_time_nxt;
      last_tap_time_r  <= last_tap_time_nxt;
      last_tap_valid_r <= last_tap_valid_nxt;
    end
  end

  // A wake needs a remembered tap and consumes it
  a_wake_needs_tap: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res_o.wake |-> last_tap_valid_r)
    else $error("wake without remembered tap");

  a_wake_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res_o.wake |=> !last_tap_valid_r)
    else $error("remembered tap kept after wake");

  a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && !cfg_i.enable |=> !touch_tracking_r && !last_tap_valid_r)
    else $error("tracking kept while disabled");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for double_tap_gesture_detector: drives touch events with
// random gaps and stalls, predicts wake/tap per request, compares in order.
// Depends on dtgd_pkg, dtgd_if.sv and the detector RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 200;

  // Gesture predictor and queue of pending wake/tap results
  class tap_scoreboard;
    logic               enable;
    logic [15:0]        dur_lim;
    logic [15:0]        move_lim;
    logic [15:0]        gap_lim;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] down_x;
    logic signed [15:0] down_y;
    logic [16:0]        peak;
    logic               tracking;
    logic [31:0]        down_t;
    logic [31:0]        last_tap_t;
    logic               last_tap_ok;
    dtgd_pkg::res_t     pending[$];
    int                 errors;
    int                 events;
    int                 results;
    int                 taps;
    int                 wakes;

    function new();
      enable      = 1'b0;
      dur_lim     = dtgd_pkg::TAP_MAX_DUR_RST;
      move_lim    = dtgd_pkg::TAP_MAX_MOVE_RST;
      gap_lim     = dtgd_pkg::DBL_MAX_GAP_RST;
      cur_x       = '0;
      cur_y       = '0;
      down_x      = '0;
      down_y      = '0;
      peak        = '0;
      tracking    = 1'b0;
      down_t      = '0;
      last_tap_t  = '0;
      last_tap_ok = 1'b0;
      errors      = 0;
      events      = 0;
      results     = 0;
      taps        = 0;
      wakes       = 0;
    endfunction

    function void set_reg(dtgd_pkg::cfg_idx_t idx, logic [15:0] data);
      case (idx)
        dtgd_pkg::CFG_ENABLE:       enable   = data[0];
        dtgd_pkg::CFG_TAP_MAX_DUR:  dur_lim  = data;
        dtgd_pkg::CFG_TAP_MAX_MOVE: move_lim = data;
        dtgd_pkg::CFG_DBL_MAX_GAP:  gap_lim  = data;
        default: ;
      endcase
    endfunction

    // Absolute distance along one axis, 17 bits wide
    function logic [16:0] axis_dist(logic signed [15:0] a, logic signed [15:0] b);
      logic signed [16:0] d;
      d = $signed({a[15], a}) - $signed({b[15], b});
      return d[16] ? 17'(-d) : 17'(d);
    endfunction

    // Advance the tracking state by one touch event and queue its result
    function void note_event(dtgd_pkg::item_t ev);
      dtgd_pkg::res_t r;
      logic [16:0]    dx;
      logic [16:0]    dy;
      logic [31:0]    held;
      logic [31:0]    since;
      r = '0;
      events++;
      if (!enable) begin
        tracking    = 1'b0;
        last_tap_ok = 1'b0;
      end else begin
        case (ev.kind)
          dtgd_pkg::KIND_POS_X, dtgd_pkg::KIND_POS_Y: begin
            if (ev.kind == dtgd_pkg::KIND_POS_X) cur_x = ev.value;
            else cur_y = ev.value;
            if (tracking) begin
              dx = axis_dist(cur_x, down_x);
              dy = axis_dist(cur_y, down_y);
              if (dx > peak) peak = dx;
              if (dy > peak) peak = dy;
            end
          end
          dtgd_pkg::KIND_CONTACT: begin
            if (ev.value == dtgd_pkg::CONTACT_DOWN) begin
              down_t   = ev.time_ms;
              down_x   = cur_x;
              down_y   = cur_y;
              peak     = '0;
              tracking = 1'b1;
            end else if (tracking) begin
              tracking = 1'b0;
              held     = ev.time_ms - down_t;
              since    = ev.time_ms - last_tap_t;
              if (held > {16'b0, dur_lim} || peak > {1'b0, move_lim}) begin
                last_tap_ok = 1'b0;
              end else if (last_tap_ok && since <= {16'b0, gap_lim}) begin
                last_tap_ok = 1'b0;
                r.wake      = 1'b1;
                r.tap       = 1'b1;
              end else begin
                last_tap_t  = ev.time_ms;
                last_tap_ok = 1'b1;
                r.tap       = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] ERROR %s", $time, msg);
    endtask

    // Compare one result against the oldest prediction
    task check_result(dtgd_pkg::res_t got);
      dtgd_pkg::res_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending: wake=%0b tap=%0b", got.wake, got.tap));
        return;
      end
      want = pending.pop_front();
      results++;
      taps  += want.tap;
      wakes += want.wake;
      if (got.wake !== want.wake || got.tap !== want.tap)
        report($sformatf("result %0d: wake %0b exp %0b, tap %0b exp %0b",
                         results, got.wake, want.wake, got.tap, want.tap));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [dtgd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dtgd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  dtgd_in_if  in_chan ();
  dtgd_out_if out_chan ();

  double_tap_gesture_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tap_scoreboard sb;
  logic  in_calm;
  logic  out_calm;
  int    sent;
  int    settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both handshakes at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_event(dtgd_pkg::item_t'{in_chan.kind, in_chan.value, in_chan.time_ms});
      if (out_chan.valid && out_chan.ready)
        sb.check_result(dtgd_pkg::res_t'{out_chan.wake, out_chan.tap});
    end
  end

  // Mostly short idle stretches, a few long ones
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Pick a span around a limit: inside, on it, just over, far over, or wrapped
  function automatic logic [31:0] near_limit(logic [15:0] lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, lim);
    if (r < 80) return 32'(lim) + $urandom_range(0, 1);
    if (r < 90) return 32'(lim) + $urandom_range(2, 500);
    return $urandom;
  endfunction

  function automatic logic signed [15:0] release_code();
    logic signed [15:0] v;
    v = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'sd0;
    if (v == dtgd_pkg::CONTACT_DOWN) v = 16'sd0;
    return v;
  endfunction

  // Result side: hold ready low for random stretches
  initial begin
    int stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 2) == 0) stall_left = pick_idle();
      end
    end
  end

  // Present one request after an optional gap, hold until accepted
  task automatic send_event(dtgd_pkg::kind_t k, logic signed [15:0] v, logic [31:0] tm);
    int gap;
    gap = in_calm ? 0 : pick_idle();
    if (gap > 0) begin
      in_chan.valid   <= 1'b0;
      in_chan.kind    <= 2'($urandom);
      in_chan.value   <= 16'($urandom);
      in_chan.time_ms <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.kind    <= k;
    in_chan.value   <= v;
    in_chan.time_ms <= tm;
    do @(posedge clk); while (!in_chan.ready);
    if (k != dtgd_pkg::KIND_OTHER) sent++;
  endtask

  // Drop valid and let every pending result drain
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(logic en, logic [15:0] dur, logic [15:0] mv, logic [15:0] gap);
    dtgd_pkg::cfg_idx_t regs[4] = '{dtgd_pkg::CFG_ENABLE, dtgd_pkg::CFG_TAP_MAX_DUR,
                                    dtgd_pkg::CFG_TAP_MAX_MOVE, dtgd_pkg::CFG_DBL_MAX_GAP};
    logic [15:0] vals[4];
    vals = '{{15'b0, en}, dur, mv, gap};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // One press: optional position, down, a few moves, release after held ms
  task automatic one_tap(logic [31:0] down_at, logic [31:0] held);
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [31:0]        reach;
    logic [15:0]        off;
    int                 moves;
    px = 16'($urandom);
    py = 16'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      send_event(dtgd_pkg::KIND_POS_X, px, down_at - 2);
      send_event(dtgd_pkg::KIND_POS_Y, py, down_at - 1);
    end
    send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, down_at);
    reach = near_limit(sb.move_lim);
    moves = $urandom_range(0, 3);
    for (int i = 0; i < moves; i++) begin
      off = (i == moves - 1) ? 16'(reach) : 16'($urandom_range(0, reach));
      if ($urandom_range(0, 1)) off = -off;
      if ($urandom_range(0, 1)) send_event(dtgd_pkg::KIND_POS_X, px + off, down_at + i);
      else send_event(dtgd_pkg::KIND_POS_Y, py + off, down_at + i);
    end
    send_event(dtgd_pkg::KIND_CONTACT, release_code(), down_at + held);
  endtask

  // Reprogram, then mostly tap trains with random content plus noise
  task automatic run_phase(logic en, logic [15:0] dur, logic [15:0] mv, logic [15:0] gap,
                           int count);
    int          start;
    int          r;
    int          extra;
    logic [31:0] clock;
    logic [31:0] held;
    logic [31:0] pause;
    logic [31:0] up_at;
    settle();
    apply_setting(en, dur, mv, gap);
    start = sent;
    clock = $urandom;
    while (sent - start < count) begin
      if ($urandom_range(0, 9) == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 19) == 0)
        clock = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 600);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        held = near_limit(sb.dur_lim);
        one_tap(clock, held);
        up_at = clock + held;
        extra = $urandom_range(1, 3);
        repeat (extra) begin
          pause = near_limit(sb.gap_lim);
          held  = near_limit(sb.dur_lim);
          one_tap(up_at + pause - held, held);
          up_at = up_at + pause;
        end
        clock = up_at + $urandom_range(0, 2 * sb.gap_lim + 50);
      end else if (r < 80) begin
        // re-press while held, or a release with no press
        if ($urandom_range(0, 1)) begin
          send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, clock);
          send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN,
                     clock + $urandom_range(0, sb.dur_lim));
          send_event(dtgd_pkg::KIND_CONTACT, release_code(), clock + near_limit(sb.dur_lim));
        end else begin
          send_event(dtgd_pkg::KIND_CONTACT, release_code(), clock);
        end
        clock = clock + $urandom_range(0, 1000);
      end else begin
        repeat ($urandom_range(1, 4))
          send_event(dtgd_pkg::kind_t'($urandom_range(0, 3)),
                     ($urandom_range(0, 3) == 0) ? dtgd_pkg::CONTACT_DOWN : 16'($urandom),
                     $urandom_range(0, 4) == 0 ? $urandom : clock + $urandom_range(0, 100));
        clock = clock + $urandom_range(0, 300);
      end
    end
  endtask

  // End the run when nothing is accepted for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb       = new();
    in_calm  = 1'b0;
    out_calm = 1'b0;
    sent     = 0;
    settings = 0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= dtgd_pkg::CFG_ENABLE;
    cfg_wdata       <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.kind    <= dtgd_pkg::KIND_OTHER;
    in_chan.value   <= '0;
    in_chan.time_ms <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: a press and release give nothing
    send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, 32'd10);
    send_event(dtgd_pkg::KIND_CONTACT, 16'sd0, 32'd20);
    settle();
    apply_setting(1'b1, dtgd_pkg::TAP_MAX_DUR_RST, dtgd_pkg::TAP_MAX_MOVE_RST,
                  dtgd_pkg::DBL_MAX_GAP_RST);

    // ignored kind with extreme fields
    send_event(dtgd_pkg::KIND_OTHER, -16'sd32768, 32'hFFFF_FFFF);
    send_event(dtgd_pkg::KIND_POS_X, 16'sd100, 32'd0);
    send_event(dtgd_pkg::KIND_POS_Y, 16'sd100, 32'd0);
    // tap at time zero, movement and duration exactly on the limits
    send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, 32'd0);
    send_event(dtgd_pkg::KIND_POS_X, 16'sd140, 32'd5);
    send_event(dtgd_pkg::KIND_CONTACT, 16'sd0, 32'd250);
    // second tap wakes, third starts a new pair
    send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, 32'd300);
    send_event(dtgd_pkg::KIND_CONTACT, -16'sd1, 32'd350);
    send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, 32'd400);
    send_event(dtgd_pkg::KIND_CONTACT, 16'sd2, 32'd450);
    // release with nothing held
    send_event(dtgd_pkg::KIND_CONTACT, 16'sd0, 32'd460);
    // press too long, then moved too far
    send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, 32'd1000);
    send_event(dtgd_pkg::KIND_CONTACT, 16'sd0, 32'd1251);
    send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, 32'd2000);
    send_event(dtgd_pkg::KIND_POS_Y, 16'sd182, 32'd2001);
    send_event(dtgd_pkg::KIND_CONTACT, 16'sd0, 32'd2002);
    // taps across the timestamp wrap, then a release stamped before its press
    send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, 32'hFFFF_FFF0);
    send_event(dtgd_pkg::KIND_CONTACT, 16'sd0, 32'h0000_0050);
    send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, 32'h0000_0060);
    send_event(dtgd_pkg::KIND_CONTACT, 16'sd0, 32'h0000_0070);
    send_event(dtgd_pkg::KIND_CONTACT, dtgd_pkg::CONTACT_DOWN, 32'h0000_0200);
    send_event(dtgd_pkg::KIND_CONTACT, 16'sd0, 32'h0000_01F0);

    run_phase(1'b1, dtgd_pkg::TAP_MAX_DUR_RST, dtgd_pkg::TAP_MAX_MOVE_RST,
              dtgd_pkg::DBL_MAX_GAP_RST, 200);
    run_phase(1'b1, 16'd0, 16'd0, 16'd0, 150);
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 150);
    run_phase(1'b1, 16'($urandom_range(0, 600)), 16'($urandom_range(0, 200)),
              16'($urandom_range(0, 900)), 200);
    run_phase(1'b0, dtgd_pkg::TAP_MAX_DUR_RST, dtgd_pkg::TAP_MAX_MOVE_RST,
              dtgd_pkg::DBL_MAX_GAP_RST, 80);
    run_phase(1'b1, 16'($urandom_range(0, 600)), 16'($urandom_range(0, 200)),
              16'($urandom_range(0, 900)), 200);
    run_phase(1'b1, dtgd_pkg::TAP_MAX_DUR_RST, dtgd_pkg::TAP_MAX_MOVE_RST,
              dtgd_pkg::DBL_MAX_GAP_RST, 100);
    settle();

    $display("%0d touch events across %0d register settings, %0d results compared",
             sb.events, settings, sb.results);
    $display("predicted %0d taps and %0d wakes; %0d mismatches", sb.taps, sb.wakes, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/dtgd_pkg.sv
hdl/dtgd_if.sv
hdl/dtgd_core.sv
hdl/double_tap_gesture_detector.sv
tb/testbench.sv
